[hdl/assert_macros.svh]
// Assertion macros used by the hasher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, a, b)
`define CHK_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hdl/sha256_pkg.sv]
// Constants, types and round functions for the SHA-256 hasher.
package sha256_pkg;
	typedef logic [31:0] word_t;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PAD   = 4'd1;
	localparam logic [3:0] ST_RND   = 4'd3;
	localparam logic [3:0] ST_OUT   = 4'd5;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef struct packed {
		logic       start;
		logic       busy;
	} cmp_ctl_t;

	function automatic word_t iv(input logic [2:0] i);
		case (i)
			3'd0: iv = 32'h6a09e667;
			3'd1: iv = 32'hbb67ae85;
			3'd2: iv = 32'h3c6ef372;
			3'd3: iv = 32'ha54ff53a;
			3'd4: iv = 32'h510e527f;
			3'd5: iv = 32'h9b05688c;
			3'd6: iv = 32'h1f83d9ab;
			default: iv = 32'h5be0cd19;
		endcase
	endfunction

	localparam word_t RK [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction
endpackage

[hdl/sha256_byte_stream_hasher.sv]
// Top level of the SHA-256 byte-stream hasher.
// Usage: one message byte per input item on data_byte/byte_present; the item
// with end_of_message high ends the message (byte_present 0 there means no
// byte). Each full 64-byte block is compressed by a round unit that reads the
// block buffer memory for its first 16 rounds, one word per round, one round a
// cycle. in_stall is low only in the idle state while no block compresses.
// On the end item the block writes padding bytes into the buffer one per cycle
// while the round unit is idle (up to 64, or 72 when two blocks are needed),
// compresses, then shows the digest as four items, part 0 first, each 64 bits
// big-endian; last_part marks part 3.
// While out_stall is high the current part holds and no new input is taken.
// After the fourth part the chaining words return to the initial values.
// Reset clears control state and byte count; chaining words take initial values.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_part,
	output logic [1:0]  part_index,
	output logic        last_part
);
	`include "assert_macros.svh"

	logic [3:0]  st_q;
	logic [60:0] cnt_q;
	logic [6:0]  pad_q;
	logic [1:0]  part_q;
	logic        second_q;
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;
	logic [3:0]  rd_addr;
	sha256_pkg::word_t rd_data;
	sha256_pkg::word_t h [8];
	sha256_pkg::cmp_ctl_t ctl;
	logic        ctl_busy;
	logic        init;
	logic        take;
	logic [63:0] bits;
	logic [6:0]  pos;

	assign take = in_valid && !in_stall;
	assign in_stall = (st_q != sha256_pkg::ST_IDLE) || ctl.busy;
	assign bits = {cnt_q, 3'b000};
	assign pos = 7'(cnt_q[5:0]) + pad_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[5:0];
		wr_data = data_byte;
		ctl.start = 1'b0;
		ctl.busy = ctl_busy;
		if (st_q == sha256_pkg::ST_IDLE && take && byte_present) begin
			wr_en = 1'b1;
			ctl.start = (cnt_q[5:0] == 6'd63);
		end else if (st_q == sha256_pkg::ST_PAD && !ctl_busy) begin
			wr_en = 1'b1;
			wr_addr = pos[5:0];
			if (pad_q == 7'd0) wr_data = sha256_pkg::PAD_BYTE;
			else if (second_q && pos[6] == 1'b0) wr_data = 8'h00;
			else if (pos[5:0] >= 6'd56) wr_data = bits[{3'(6'd63 - pos[5:0]), 3'b000} +: 8];
			else wr_data = 8'h00;
			if (pos[5:0] == 6'd63) ctl.start = 1'b1;
		end
	end

	sha256_buf u_buf (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	sha256_core u_core (
		.clk(clk), .arst_n(arst_n), .start(ctl.start), .rd_addr(rd_addr),
		.rd_data(rd_data), .init(init), .busy(ctl_busy), .h_q(h)
	);

	assign init = (st_q == sha256_pkg::ST_OUT) && !out_stall && (part_q == 2'd3);
	assign out_valid = (st_q == sha256_pkg::ST_OUT);
	assign part_index = part_q;
	assign last_part = (part_q == 2'd3);
	always_comb begin
		case (part_q)
			2'd0: digest_part = {h[0], h[1]};
			2'd1: digest_part = {h[2], h[3]};
			2'd2: digest_part = {h[4], h[5]};
			default: digest_part = {h[6], h[7]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sha256_pkg::ST_IDLE;
			cnt_q <= '0;
			pad_q <= '0;
			part_q <= '0;
			second_q <= 1'b0;
		end else begin
			case (st_q)
				sha256_pkg::ST_IDLE: begin
					if (take) begin
						if (end_of_message) begin
							st_q <= sha256_pkg::ST_PAD;
							pad_q <= '0;
							second_q <= 1'b0;
							if (byte_present) cnt_q <= cnt_q + 61'd1;
						end else if (byte_present) begin
							cnt_q <= cnt_q + 61'd1;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					if (!ctl_busy) begin
						pad_q <= pad_q + 7'd1;
						if (pad_q == 7'd0 && pos[5:0] >= 6'd56) second_q <= 1'b1;
						if (pos[5:0] == 6'd63) begin
							st_q <= sha256_pkg::ST_RND;
							if (second_q || !(pad_q == 7'd0 && pos[5:0] >= 6'd56))
								second_q <= second_q;
						end
					end
				end
				sha256_pkg::ST_RND: begin
					if (!ctl_busy && !ctl.start) begin
						if (second_q && pos[6] == 1'b1) begin
							st_q <= sha256_pkg::ST_PAD;
						end else begin
							st_q <= sha256_pkg::ST_OUT;
							part_q <= '0;
						end
					end
				end
				sha256_pkg::ST_OUT: begin
					if (!out_stall) begin
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							st_q <= sha256_pkg::ST_IDLE;
							cnt_q <= '0;
						end
					end
				end
				default: st_q <= sha256_pkg::ST_IDLE;
			endcase
		end
	end

	`CHK_IMPLY(a_no_take_busy, clk, arst_n, ctl_busy, in_stall)
	`CHK_IMPLY(a_out_idle_core, clk, arst_n, out_valid, !ctl_busy)
	`CHK_NEXT(a_reset_after_last, clk, arst_n, out_valid && last_part && !out_stall,
		!out_valid && cnt_q == 61'd0)
endmodule

[hdl/sha256_buf.sv]
// Block buffer memory: byte-wide writes, word-wide synchronous reads.
module sha256_buf (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [5:0]            wr_addr,
	input  logic [7:0]            wr_data,
	input  logic [3:0]            rd_addr,
	output sha256_pkg::word_t     rd_data
);
	logic [7:0] mem0 [16];
	logic [7:0] mem1 [16];
	logic [7:0] mem2 [16];
	logic [7:0] mem3 [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_addr[1:0])
				2'd0: mem0[wr_addr[5:2]] <= wr_data;
				2'd1: mem1[wr_addr[5:2]] <= wr_data;
				2'd2: mem2[wr_addr[5:2]] <= wr_data;
				default: mem3[wr_addr[5:2]] <= wr_data;
			endcase
		end
		rd_data <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
	end
endmodule

[hdl/sha256_core.sv]
// Compression engine: one round per cycle, schedule held in a 16-word window.
module sha256_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic [3:0]            rd_addr,
	input  sha256_pkg::word_t     rd_data,
	input  logic                  init,
	output logic                  busy,
	output sha256_pkg::word_t     h_q [8]
);
	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RND  = 2'd1;
	localparam logic [1:0] C_ADD  = 2'd2;

	logic [1:0] st_q;
	logic [6:0] rnd_q;
	sha256_pkg::word_t v_q [8];
	sha256_pkg::word_t w_q [16];
	sha256_pkg::word_t w, s0, s1, t1, t2, ch, mj;
	sha256_pkg::word_t a15, a2;

	assign busy = (st_q != C_IDLE);
	assign rd_addr = (st_q == C_IDLE) ? 4'd0 : 4'(rnd_q[3:0] + 4'd1);

	always_comb begin
		a15 = w_q[1];
		a2  = w_q[14];
		if (rnd_q < 7'd16) begin
			w = rd_data;
		end else begin
			w = w_q[0] + (sha256_pkg::ror(a15, 7) ^ sha256_pkg::ror(a15, 18) ^ (a15 >> 3))
				+ w_q[9] + (sha256_pkg::ror(a2, 17) ^ sha256_pkg::ror(a2, 19) ^ (a2 >> 10));
		end
		s1 = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
			^ sha256_pkg::ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + sha256_pkg::RK[rnd_q[5:0]] + w;
		s0 = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
			^ sha256_pkg::ror(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			rnd_q <= '0;
			for (int j = 0; j < 8; j++) h_q[j] <= sha256_pkg::iv(3'(j));
		end else begin
			case (st_q)
				C_IDLE: begin
					if (init) begin
						for (int j = 0; j < 8; j++) h_q[j] <= sha256_pkg::iv(3'(j));
					end
					if (start) begin
						st_q <= C_RND;
						rnd_q <= '0;
					end
				end
				C_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd63) st_q <= C_ADD;
				end
				C_ADD: begin
					for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == C_IDLE && start) begin
			for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
		end else if (st_q == C_RND) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= w;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule

[tb/testbench.sv]
// Self-checking testbench for the SHA-256 byte-stream hasher against a digest predictor.
`timescale 1ns / 100ps
module testbench;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;

	typedef struct packed {
		logic [63:0] digest;
		logic [1:0]  index;
		logic        last;
	} digest_part_t;

	localparam logic [31:0] H_INIT [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] K_ROUND [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
	localparam int WATCHDOG_LIMIT = 20000;

	logic [31:0]  hash_state [8];
	logic [7:0]   msg_block [64];
	logic [60:0]  msg_length;
	digest_part_t pending_parts [$];
	int           failures;
	int           idle_cycles;
	bit           gaps_on;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .byte_present(byte_present),
		.end_of_message(end_of_message), .out_valid(out_valid), .out_stall(out_stall),
		.digest_part(digest_part), .part_index(part_index), .last_part(last_part)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
			hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ K_ROUND[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic predict_digest(input logic [7:0] db, input logic bp, input logic eom);
		int tail;
		logic [63:0] bits;
		if (bp) begin
			msg_block[msg_length[5:0]] = db;
			msg_length = msg_length + 61'd1;
			if (msg_length[5:0] == 6'd0)
				compress_block();
		end
		if (!eom)
			return;
		tail = msg_length[5:0];
		msg_block[tail] = sha256_pkg::PAD_BYTE;
		tail++;
		if (tail > 56) begin
			for (int i = tail; i < 64; i++)
				msg_block[i] = 8'h00;
			compress_block();
			tail = 0;
		end
		for (int i = tail; i < 56; i++)
			msg_block[i] = 8'h00;
		bits = {msg_length, 3'b000};
		for (int k = 0; k < 8; k++)
			msg_block[56+k] = bits[63-8*k -: 8];
		compress_block();
		for (int k = 0; k < 4; k++)
			pending_parts.push_back({hash_state[2*k], hash_state[2*k+1], 2'(k), k == 3});
		hash_state = H_INIT;
		msg_length = '0;
	endtask

	task automatic send_item(input logic [7:0] db, input logic bp, input logic eom);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= db;
		byte_present <= bp;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		predict_digest(db, bp, eom);
	endtask

	task automatic send_message(input int len, input bit empty_end);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom), 1'b1, !empty_end && i == len - 1);
		if (empty_end || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_directed();
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);
		send_message(3, 1'b1);
	endtask

	task automatic test_padding_boundaries();
		send_message(56, 1'b1);
		send_message(64, 1'b0);
	endtask

	task automatic test_drain_pause();
		send_message(2, 1'b0);
		in_valid <= 1'b0;
		while (pending_parts.size() != 0)
			@(posedge clk);
		send_message(1, 1'b0);
	endtask

	task automatic test_random_messages();
		int sent;
		sent = 0;
		while (sent < 8) begin
			int len;
			len = $urandom_range(0, 6);
			send_message(len, $urandom_range(0, 3) == 0);
			sent += len + 1;
			if (sent > 3)
				gaps_on = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_parts.size() == 0) begin
				$error("digest part with none expected");
				failures++;
			end else begin
				digest_part_t exp;
				exp = pending_parts.pop_front();
				if (digest_part !== exp.digest) begin
					$error("digest_part expected %h actual %h", exp.digest, digest_part);
					failures++;
				end
				if (part_index !== exp.index) begin
					$error("part_index expected %0d actual %0d", exp.index, part_index);
					failures++;
				end
				if (last_part !== exp.last) begin
					$error("last_part expected %0d actual %0d", exp.last, last_part);
					failures++;
				end
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sha256_byte_stream_hasher test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		failures = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		hash_state = H_INIT;
		msg_length = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_padding_boundaries();
		test_drain_pause();
		test_random_messages();
		in_valid <= 1'b0;
		while (pending_parts.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("sha256_byte_stream_hasher test passed");
		else
			$display("sha256_byte_stream_hasher test failed");
		$finish;
	end
endmodule
